[rtl/core/plsc_pkg.sv]
`default_nettype none
package plsc_pkg;
  localparam int LineCount = 48;
  localparam int LineW = 6;
  localparam int PinMax = 16'hFFFF;

  localparam logic [3:0] FnRead = 4'd0;
  localparam logic [3:0] FnWrite = 4'd1;
  localparam logic [3:0] FnAlloc = 4'd2;
  localparam logic [3:0] FnPinSec = 4'd3;
  localparam logic [3:0] FnUnpinSec = 4'd4;
  localparam logic [3:0] FnPinLine = 4'd5;
  localparam logic [3:0] FnUnpinLine = 4'd6;
  localparam logic [3:0] FnFree = 4'd7;
  localparam logic [3:0] FnFlush = 4'd8;

  localparam logic [2:0] StDone = 3'd0;
  localparam logic [2:0] StFilled = 3'd1;
  localparam logic [2:0] StFull = 3'd2;
  localparam logic [2:0] StAbsent = 3'd3;
  localparam logic [2:0] StMisuse = 3'd4;
endpackage
`default_nettype wire

[rtl/core/plsc_scan.sv]
`default_nettype none
// one line entry per cycle while en_i is high: hit search, free search and lru compare
module plsc_scan (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      clear_i,
  input  wire logic                      en_i,
  input  wire logic [plsc_pkg::LineW-1:0] idx_i,
  input  wire logic                      valid_i,
  input  wire logic                      tag_eq_i,
  input  wire logic                      pinned_i,
  input  wire logic [63:0]               use_i,
  output logic                           hit_o,
  output logic [plsc_pkg::LineW-1:0]     hit_idx_o,
  output logic                           lofree_o,
  output logic [plsc_pkg::LineW-1:0]     lofree_idx_o,
  output logic                           hifree_o,
  output logic [plsc_pkg::LineW-1:0]     hifree_idx_o,
  output logic                           lru_o,
  output logic [plsc_pkg::LineW-1:0]     lru_idx_o
);
  import plsc_pkg::*;
  logic [63:0] best_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_o <= 1'b0; lofree_o <= 1'b0; hifree_o <= 1'b0; lru_o <= 1'b0;
      hit_idx_o <= '0; lofree_idx_o <= '0; hifree_idx_o <= '0; lru_idx_o <= '0;
      best_q <= '0;
    end else if (clear_i) begin
      hit_o <= 1'b0; lofree_o <= 1'b0; hifree_o <= 1'b0; lru_o <= 1'b0;
    end else if (en_i) begin
      if (valid_i && tag_eq_i && !hit_o) begin
        hit_o <= 1'b1; hit_idx_o <= idx_i;
      end
      if (!valid_i) begin
        hifree_o <= 1'b1; hifree_idx_o <= idx_i;
        if (!lofree_o) begin
          lofree_o <= 1'b1; lofree_idx_o <= idx_i;
        end
      end
      // free lines enter the compare too, but lru is used only when no line is free
      if (!pinned_i && (!lru_o || use_i < best_q)) begin
        lru_o <= 1'b1; lru_idx_o <= idx_i; best_q <= use_i;
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/pinned_lru_sector_cache_control.sv]
`default_nettype none
// fetch, allocate, pin and unpin by sector: scan reads of all 48 lines, drain, pick,
//   read, update; line ops read, then update; unknown ops answer straight from idle
// flush: visits all 48 lines, one write-back per dirty line, last held back
// one transaction at a time, busy high until the last result is shown (never for unknown ops)
// reset: asynchronous active low; sets tick to 1, clears valid and dirty marks
// results are shown for one cycle with valid_o; the receiver cannot stall
module pinned_lru_sector_cache_control (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  func_i,
  input  wire logic [31:0] sector_i,
  input  wire logic [5:0]  line_index_i,
  output logic             valid_o,
  output logic [2:0]       status_o,
  output logic [5:0]       line_o,
  output logic             writeback_valid_o,
  output logic [31:0]      writeback_sector_o,
  output logic             fill_valid_o,
  output logic             last_o
);
  import plsc_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SScan = 3'd1;
  localparam logic [2:0] SRead = 3'd2;
  localparam logic [2:0] SAct = 3'd3;
  localparam logic [2:0] SFlush = 3'd4;
  localparam logic [2:0] SFlushEnd = 3'd5;
  localparam logic [2:0] SDrain = 3'd6;
  localparam logic [2:0] SFlushTail = 3'd7;

  logic [2:0] state_q;
  logic [3:0] func_q;
  logic [31:0] sec_q;
  logic [LineW-1:0] idx_q, tgt_q;
  logic [63:0] tick_q;
  logic [LineCount-1:0] valid_q, dirty_q;
  logic [63:0] use_mem [LineCount];
  logic [15:0] pin_mem [LineCount];
  logic [31:0] tag_mem [LineCount];
  logic [31:0] pend_tag_q;
  logic [LineW-1:0] pend_idx_q;
  logic pend_q;

  // registered read of the target line
  logic [63:0] rd_use_q;
  logic [15:0] rd_pin_q;
  logic [31:0] rd_tag_q;

  // registered read of the line under scan, lagging idx_q by one register
  logic sc_en_q, sc_fl_q;
  logic [LineW-1:0] sc_idx_q;
  logic [63:0] sc_use_q;
  logic [15:0] sc_pin_q;
  logic [31:0] sc_tag_q;

  logic hit, lofree, hifree, lru;
  logic [LineW-1:0] hit_idx, lofree_idx, hifree_idx, lru_idx;
  logic scan_en, scan_clr;
  logic [LineW-1:0] last_idx;
  assign last_idx = LineW'(LineCount - 1);

  assign scan_clr = (state_q == SIdle) && start;
  assign scan_en = (state_q == SScan);

  plsc_scan u_scan (
    .clk_i, .rst_ni, .clear_i(scan_clr), .en_i(sc_en_q), .idx_i(sc_idx_q),
    .valid_i(valid_q[sc_idx_q]), .tag_eq_i(sc_tag_q == sec_q),
    .pinned_i(sc_pin_q != 16'd0), .use_i(sc_use_q),
    .hit_o(hit), .hit_idx_o(hit_idx), .lofree_o(lofree), .lofree_idx_o(lofree_idx),
    .hifree_o(hifree), .hifree_idx_o(hifree_idx), .lru_o(lru), .lru_idx_o(lru_idx)
  );

  assign busy = (state_q != SIdle);

  logic is_fetch, is_alloc, is_sec;
  assign is_fetch = (func_q == FnRead) || (func_q == FnWrite);
  assign is_alloc = (func_q == FnAlloc);
  assign is_sec = (func_q == FnPinSec) || (func_q == FnUnpinSec);

  // target choice after the scan
  logic tgt_ok;
  logic [LineW-1:0] tgt;
  logic tgt_miss;
  always_comb begin
    tgt_ok = 1'b0; tgt = '0; tgt_miss = 1'b0;
    if (is_fetch) begin
      if (hit) begin tgt_ok = 1'b1; tgt = hit_idx; end
      else if (hifree) begin tgt_ok = 1'b1; tgt = hifree_idx; tgt_miss = 1'b1; end
      else if (lru) begin tgt_ok = 1'b1; tgt = lru_idx; tgt_miss = 1'b1; end
    end else if (is_alloc) begin
      tgt_miss = 1'b1;
      if (lofree) begin tgt_ok = 1'b1; tgt = lofree_idx; end
      else if (lru) begin tgt_ok = 1'b1; tgt = lru_idx; end
    end else if (is_sec) begin
      tgt_ok = hit; tgt = hit_idx;
    end
  end

  logic miss_q;
  always_ff @(posedge clk_i) begin
    rd_use_q <= use_mem[tgt_q];
    rd_pin_q <= pin_mem[tgt_q];
    rd_tag_q <= tag_mem[tgt_q];
    sc_use_q <= use_mem[idx_q];
    sc_pin_q <= pin_mem[idx_q];
    sc_tag_q <= tag_mem[idx_q];
  end

  logic rd_dirty;
  assign rd_dirty = dirty_q[tgt_q] && valid_q[tgt_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; func_q <= '0; sec_q <= '0; idx_q <= '0;
      tgt_q <= '0; tick_q <= 64'd1; valid_q <= '0; dirty_q <= '0;
      pend_q <= 1'b0; pend_tag_q <= '0; pend_idx_q <= '0; miss_q <= 1'b0;
      sc_en_q <= 1'b0; sc_fl_q <= 1'b0; sc_idx_q <= '0;
      valid_o <= 1'b0; status_o <= '0; line_o <= '0; writeback_valid_o <= 1'b0;
      writeback_sector_o <= '0; fill_valid_o <= 1'b0; last_o <= 1'b0;
    end else begin
      valid_o <= 1'b0; status_o <= StDone; line_o <= '0; writeback_valid_o <= 1'b0;
      writeback_sector_o <= '0; fill_valid_o <= 1'b0; last_o <= 1'b0;
      sc_en_q <= scan_en; sc_fl_q <= (state_q == SFlush); sc_idx_q <= idx_q;
      case (state_q)
        SIdle: if (start) begin
          func_q <= func_i; sec_q <= sector_i; idx_q <= '0;
          pend_q <= 1'b0;
          if ((func_i == FnRead || func_i == FnWrite || func_i == FnAlloc)
              && tick_q != '1) tick_q <= tick_q + 64'd1;
          if (func_i == FnFlush) state_q <= SFlush;
          else if (func_i == FnPinLine || func_i == FnUnpinLine || func_i == FnFree) begin
            tgt_q <= line_index_i; state_q <= SRead;
          end else if (func_i > FnFlush) begin
            valid_o <= 1'b1; status_o <= StAbsent; last_o <= 1'b1; state_q <= SIdle;
          end else state_q <= SScan;
        end
        SScan: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == last_idx) state_q <= SDrain;
        end
        SDrain: begin
          // last line read is still in flight
          if (func_q == FnFlush) state_q <= SFlushTail;
          else state_q <= SAct;
        end
        SAct: begin
          // choose target, then read it next cycle
          if (!tgt_ok) begin
            valid_o <= 1'b1; last_o <= 1'b1;
            status_o <= (is_sec) ? StAbsent : StFull;
            state_q <= SIdle;
          end else begin
            tgt_q <= tgt; miss_q <= tgt_miss;
            if (is_sec) func_q <= func_q + 4'd2;
            state_q <= SRead;
          end
        end
        SRead: state_q <= SFlushEnd;
        SFlushEnd: begin
          // registered target data is valid here
          valid_o <= 1'b1; last_o <= 1'b1; line_o <= tgt_q; state_q <= SIdle;
          if (is_fetch || is_alloc) begin
            if (!miss_q) begin
              if (rd_pin_q == 16'(PinMax)) status_o <= StMisuse;
              else begin
                if (func_q == FnWrite) dirty_q[tgt_q] <= 1'b1;
              end
            end else begin
              status_o <= is_alloc ? StDone : StFilled;
              fill_valid_o <= !is_alloc;
              writeback_valid_o <= rd_dirty;
              writeback_sector_o <= rd_dirty ? rd_tag_q : 32'd0;
              valid_q[tgt_q] <= 1'b1;
              dirty_q[tgt_q] <= (func_q != FnRead);
            end
          end else if (tgt_q >= LineW'(LineCount) || !valid_q[tgt_q]) begin
            status_o <= StAbsent;
          end else if (func_q == FnPinLine) begin
            if (rd_pin_q == 16'(PinMax)) status_o <= StMisuse;
          end else if (func_q == FnUnpinLine) begin
            if (rd_pin_q == 16'd0) status_o <= StMisuse;
          end else begin
            if (rd_pin_q != 16'd1) status_o <= StMisuse;
            else begin valid_q[tgt_q] <= 1'b0; dirty_q[tgt_q] <= 1'b0; end
          end
        end
        SFlush: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == last_idx) state_q <= SDrain;
        end
        SFlushTail: begin
          // flush tail: emit held result with last, or a bare done result if none is held
          valid_o <= 1'b1; last_o <= 1'b1; state_q <= SIdle;
          if (pend_q) begin
            line_o <= pend_idx_q; writeback_valid_o <= 1'b1;
            writeback_sector_o <= pend_tag_q;
          end
        end
        default: state_q <= SIdle;
      endcase
      // flush visit: hold one result back so the final one can carry last
      if (sc_fl_q && valid_q[sc_idx_q] && dirty_q[sc_idx_q]) begin
        dirty_q[sc_idx_q] <= 1'b0;
        pend_q <= 1'b1; pend_idx_q <= sc_idx_q; pend_tag_q <= sc_tag_q;
        if (pend_q) begin
          valid_o <= 1'b1; line_o <= pend_idx_q; writeback_valid_o <= 1'b1;
          writeback_sector_o <= pend_tag_q;
        end
      end
    end
  end

  // line memories
  logic mem_we;
  assign mem_we = (state_q == SFlushEnd) && (func_q != FnFlush);
  logic [LineW-1:0] ti;
  assign ti = tgt_q;
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      if (is_fetch || is_alloc) begin
        if (!miss_q) begin
          if (rd_pin_q != 16'(PinMax)) begin
            use_mem[ti] <= tick_q; pin_mem[ti] <= rd_pin_q + 16'd1;
          end
        end else begin
          tag_mem[ti] <= sec_q; use_mem[ti] <= tick_q;
          pin_mem[ti] <= is_alloc ? 16'd0 : 16'd1;
        end
      end else if (ti < LineW'(LineCount) && valid_q[ti]) begin
        if (func_q == FnPinLine && rd_pin_q != 16'(PinMax)) pin_mem[ti] <= rd_pin_q + 16'd1;
        else if (func_q == FnUnpinLine && rd_pin_q != 16'd0) pin_mem[ti] <= rd_pin_q - 16'd1;
        else if (func_q == FnFree && rd_pin_q == 16'd1) begin
          pin_mem[ti] <= 16'd0; use_mem[ti] <= 64'd0;
        end
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/plsc_checker.sv]
`default_nettype none
module plsc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic valid_o,
  input wire logic [2:0] status_o,
  input wire logic writeback_valid_o,
  input wire logic fill_valid_o,
  input wire logic last_o
);
  import plsc_pkg::*;
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> status_o <= StMisuse) else $error("bad status");
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && fill_valid_o) |-> (status_o == StFilled && last_o)) else $error("fill status");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy || valid_o) else $error("start not taken");
  a_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && writeback_valid_o) |-> (status_o == StDone || status_o == StFilled))
    else $error("writeback status");
endmodule
bind pinned_lru_sector_cache_control plsc_checker u_chk (.*);
`default_nettype wire

[tb/sv/pinned_lru_sector_cache_control_tb.sv]
`default_nettype none
module pinned_lru_sector_cache_control_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import plsc_pkg::*;

  typedef struct packed {
    logic [3:0]  fn;
    logic [31:0] sec;
    logic [5:0]  li;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  st;
    logic [5:0]  ln;
    logic        wbv;
    logic [31:0] wbs;
    logic        fv;
    logic        lst;
  } resp_t;

  localparam int unsigned PinFull = PinMax;
  localparam longint CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic [3:0]  func_i = '0;
  logic [31:0] sector_i = '0;
  logic [5:0]  line_index_i = '0;
  wire         busy;
  wire         valid_o;
  wire  [2:0]  status_o;
  wire  [5:0]  line_o;
  wire         writeback_valid_o;
  wire  [31:0] writeback_sector_o;
  wire         fill_valid_o;
  wire         last_o;

  pinned_lru_sector_cache_control u_top (
    .clk_i, .rst_ni, .start, .busy, .func_i, .sector_i, .line_index_i,
    .valid_o, .status_o, .line_o, .writeback_valid_o, .writeback_sector_o,
    .fill_valid_o, .last_o
  );

  // shadow copy of the cache bookkeeping
  logic [63:0] tick;
  logic [63:0] use_time [LineCount];
  logic        dirty [LineCount];
  logic [15:0] pins [LineCount];
  logic [31:0] tag [LineCount];

  cmd_t  pending_cmds[$];
  resp_t expected_resps[$];
  int    errors = 0;
  int    n_sent = 0;
  int    n_resp = 0;
  int    n_wb = 0;
  int    n_flush = 0;
  bit    quiet = 1'b0;
  longint cycles = 0;

  initial forever #4 clk_i = ~clk_i;

  function automatic resp_t mk(logic [2:0] st, logic [5:0] ln, logic wbv = 0,
                               logic [31:0] wbs = 0, logic fv = 0,
                               logic lst = 1);
    resp_t r;
    r.st = st; r.ln = ln; r.wbv = wbv; r.wbs = wbs; r.fv = fv; r.lst = lst;
    return r;
  endfunction

  function automatic int find_line(logic [31:0] s);
    for (int i = 0; i < LineCount; i++)
      if (use_time[i] != 0 && tag[i] == s) return i;
    return -1;
  endfunction

  function automatic int pick_victim(bit highest_free);
    int pick;
    logic [63:0] best;
    pick = -1;
    best = '0;
    for (int i = 0; i < LineCount; i++)
      if (use_time[i] == 0) begin
        if (!highest_free) return i;
        pick = i;
      end
    if (pick >= 0) return pick;
    for (int i = 0; i < LineCount; i++) begin
      if (pins[i] != 0) continue;
      if (pick < 0 || use_time[i] < best) begin
        pick = i;
        best = use_time[i];
      end
    end
    return pick;
  endfunction

  task automatic predict_cache(cmd_t c);
    int v;
    int n;
    logic [5:0] li;
    logic [3:0] fn;
    bit wb;
    logic [31:0] old;
    fn = c.fn;
    li = c.li;
    case (fn)
      FnRead, FnWrite, FnAlloc: begin
        if (tick != '1) tick++;
        v = (fn == FnAlloc) ? -1 : find_line(c.sec);
        if (v >= 0) begin
          if (pins[v] == PinFull) begin
            expected_resps.push_back(mk(StMisuse, 6'(v)));
          end else begin
            if (fn == FnWrite) dirty[v] = 1'b1;
            use_time[v] = tick;
            pins[v]++;
            expected_resps.push_back(mk(StDone, 6'(v)));
          end
          return;
        end
        v = pick_victim(fn != FnAlloc);
        if (v < 0) begin
          expected_resps.push_back(mk(StFull, 0));
          return;
        end
        wb = use_time[v] != 0 && dirty[v];
        old = wb ? tag[v] : '0;
        if (wb) n_wb++;
        tag[v] = c.sec;
        use_time[v] = tick;
        dirty[v] = (fn != FnRead);
        pins[v] = (fn == FnAlloc) ? 16'd0 : 16'd1;
        expected_resps.push_back(mk(fn == FnAlloc ? StDone : StFilled, 6'(v), wb, old,
                                    fn != FnAlloc));
        return;
      end
      FnPinSec, FnUnpinSec: begin
        v = find_line(c.sec);
        if (v < 0) begin
          expected_resps.push_back(mk(StAbsent, 0));
          return;
        end
        li = 6'(v);
        fn = fn + 4'd2;
      end
      FnPinLine, FnUnpinLine, FnFree: begin
        if (li >= LineCount || use_time[li] == 0) begin
          expected_resps.push_back(mk(StAbsent, li));
          return;
        end
      end
      FnFlush: begin
        n = 0;
        n_flush++;
        for (int i = 0; i < LineCount; i++)
          if (use_time[i] != 0 && dirty[i]) begin
            expected_resps.push_back(mk(StDone, 6'(i), 1, tag[i], 0, 0));
            dirty[i] = 1'b0;
            n++;
          end
        if (n == 0) expected_resps.push_back(mk(StDone, 0));
        else expected_resps[$].lst = 1'b1;
        return;
      end
      default: begin
        expected_resps.push_back(mk(StAbsent, 0));
        return;
      end
    endcase
    if (fn == FnPinLine) begin
      if (pins[li] == PinFull) begin
        expected_resps.push_back(mk(StMisuse, li));
        return;
      end
      pins[li]++;
    end else if (fn == FnUnpinLine) begin
      if (pins[li] == 0) begin
        expected_resps.push_back(mk(StMisuse, li));
        return;
      end
      pins[li]--;
    end else begin
      if (pins[li] != 1) begin
        expected_resps.push_back(mk(StMisuse, li));
        return;
      end
      pins[li] = 0;
      dirty[li] = 0;
      use_time[li] = 0;
      tag[li] = 0;
    end
    expected_resps.push_back(mk(StDone, li));
  endtask

  // driver: start is lowered after every accepted command and raised again, at random unless quiet, while commands wait
  always @(posedge clk_i) begin
    cmd_t c;
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (start && !busy) begin
        predict_cache(pending_cmds.pop_front());
        n_sent++;
      end
      if (start && !busy) begin
        start <= 1'b0;
      end else if (!start && pending_cmds.size() != 0 &&
                   (quiet || $urandom_range(99) >= 28)) begin
        c = pending_cmds[0];
        start <= 1'b1;
        func_i <= c.fn;
        sector_i <= c.sec;
        line_index_i <= c.li;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    resp_t got;
    resp_t exp_r;
    if (rst_ni && valid_o) begin
      got = mk(status_o, line_o, writeback_valid_o, writeback_sector_o,
               fill_valid_o, last_o);
      n_resp++;
      if (expected_resps.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, got);
        errors++;
      end else begin
        exp_r = expected_resps.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, exp_r, got);
          errors++;
        end
      end
    end
  end

  initial begin
    wait (rst_ni);
    wait (cycles > CycleLimit);
    $display("%0t: timeout, %0d results still expected", $realtime,
             expected_resps.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic cmd_t rcmd(logic [3:0] fn, logic [31:0] s, logic [5:0] li);
    cmd_t c;
    c.fn = fn; c.sec = s; c.li = li;
    return c;
  endfunction

  task automatic drain();
    wait (pending_cmds.size() == 0 && !start && expected_resps.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] pool [16];
    int r;
    tick = 64'd1;
    for (int i = 0; i < LineCount; i++) begin
      use_time[i] = '0; dirty[i] = 0; pins[i] = '0; tag[i] = '0;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every function, misuse and absent cases
    pending_cmds.push_back(rcmd(FnFlush, 0, 0));
    pending_cmds.push_back(rcmd(FnRead, 32'hFFFF_FFFF, 0));
    pending_cmds.push_back(rcmd(FnWrite, 32'h0, 6'h3F));
    pending_cmds.push_back(rcmd(FnRead, 32'hFFFF_FFFF, 0));
    pending_cmds.push_back(rcmd(FnAlloc, 32'h5555_AAAA, 0));
    pending_cmds.push_back(rcmd(FnPinSec, 32'h5555_AAAA, 0));
    pending_cmds.push_back(rcmd(FnUnpinSec, 32'h5555_AAAA, 0));
    pending_cmds.push_back(rcmd(FnUnpinSec, 32'h5555_AAAA, 0));
    pending_cmds.push_back(rcmd(FnPinSec, 32'h1234, 0));
    pending_cmds.push_back(rcmd(FnUnpinSec, 32'h1234, 0));
    pending_cmds.push_back(rcmd(FnPinLine, 0, 47));
    pending_cmds.push_back(rcmd(FnPinLine, 0, 48));
    pending_cmds.push_back(rcmd(FnUnpinLine, 0, 6'h3F));
    pending_cmds.push_back(rcmd(FnFree, 0, 5));
    pending_cmds.push_back(rcmd(FnFree, 0, 47));
    pending_cmds.push_back(rcmd(FnUnpinLine, 0, 46));
    pending_cmds.push_back(rcmd(FnFree, 0, 46));
    pending_cmds.push_back(rcmd(4'd9, 32'hFFFF_FFFF, 6'h3F));
    pending_cmds.push_back(rcmd(4'd15, 0, 0));
    pending_cmds.push_back(rcmd(FnFlush, 0, 0));
    pending_cmds.push_back(rcmd(FnFlush, 0, 0));
    drain();

    // fill every line pinned, then see no line free
    for (int i = 0; i < LineCount; i++)
      pending_cmds.push_back(rcmd(FnWrite, 32'h100 + i, 0));
    pending_cmds.push_back(rcmd(FnRead, 32'hDEAD, 0));
    pending_cmds.push_back(rcmd(FnAlloc, 32'hBEEF, 0));
    pending_cmds.push_back(rcmd(FnFlush, 0, 0));
    for (int i = 0; i < LineCount; i += 2)
      pending_cmds.push_back(rcmd(FnUnpinLine, 0, 6'(i)));
    drain();

    // random: sectors from a small pool so hits, evictions and pins happen
    for (int i = 0; i < 16; i++) pool[i] = $urandom;
    for (int k = 0; k < 480; k++) begin
      if (k == 150) quiet = 1'b1;
      if (k == 250) quiet = 1'b0;
      if (k == 300)
        wait (pending_cmds.size() == 0 && !start && expected_resps.size() == 0);
      r = $urandom_range(99);
      if (r < 25)
        pending_cmds.push_back(rcmd(FnRead, $urandom_range(3) == 0 ? $urandom
                                    : pool[$urandom_range(15)], 6'($urandom)));
      else if (r < 40)
        pending_cmds.push_back(rcmd(FnWrite, pool[$urandom_range(15)], 6'($urandom)));
      else if (r < 48)
        pending_cmds.push_back(rcmd(FnAlloc, $urandom, 6'($urandom)));
      else if (r < 56)
        pending_cmds.push_back(rcmd(FnPinSec, pool[$urandom_range(15)], 6'($urandom)));
      else if (r < 66)
        pending_cmds.push_back(rcmd(FnUnpinSec, pool[$urandom_range(15)], 6'($urandom)));
      else if (r < 72)
        pending_cmds.push_back(rcmd(FnPinLine, $urandom, 6'($urandom_range(49))));
      else if (r < 82)
        pending_cmds.push_back(rcmd(FnUnpinLine, $urandom, 6'($urandom)));
      else if (r < 92)
        pending_cmds.push_back(rcmd(FnFree, $urandom, 6'($urandom_range(50))));
      else if (r < 97)
        pending_cmds.push_back(rcmd(FnFlush, $urandom, 6'($urandom)));
      else
        pending_cmds.push_back(rcmd(4'($urandom_range(15, 9)), $urandom, 6'($urandom)));
      if (pending_cmds.size() > 4)
        wait (pending_cmds.size() <= 4);
    end
    wait (pending_cmds.size() == 0 && !start);
    wait (expected_resps.size() == 0);
    repeat (120) @(posedge clk_i);
    $display("covered %0d commands, %0d results, %0d write-backs on eviction",
             n_sent, n_resp, n_wb);
    $display("including %0d flush runs, full-cache and pin misuse cases", n_flush);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
rtl/core/plsc_pkg.sv
rtl/core/plsc_scan.sv
rtl/core/pinned_lru_sector_cache_control.sv
rtl/core/plsc_checker.sv
tb/sv/pinned_lru_sector_cache_control_tb.sv
